// ===== hdl/keqm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keqm_pkg
// Shared types and constants of the key event queue and matrix block.
// ----------------------------------------------------------------------------
package keqm_pkg;

   localparam int QUEUE_DEPTH     = 512;
   localparam int IndexWidth      = $clog2(QUEUE_DEPTH);
   localparam int CountWidth      = $clog2(QUEUE_DEPTH + 1);
   localparam int QueueCountWidth = 10;
   localparam int MatrixWidth     = 64;
   localparam int BitIndexWidth   = $clog2(MatrixWidth);

   // right-shift key sits at row 6, column 4
   localparam logic [BitIndexWidth-1:0] ShiftRowBit = BitIndexWidth'(6 * 8 + 4);
   localparam logic [BitIndexWidth-1:0] ShiftColBit = BitIndexWidth'(4 * 8 + 6);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POLL = 1'b1
   } op_type;

   typedef struct packed {
      logic       released;
      logic       pressed;
      logic [7:0] code;
   } event_type;

   localparam int EventWidth = $bits(event_type);

   typedef struct packed {
      logic      apply;
      event_type key_event;
   } apply_type;

endpackage : keqm_pkg
`default_nettype wire

// ===== hdl/keqm_event_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keqm_event_ram
// Event store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module keqm_event_ram (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [keqm_pkg::IndexWidth-1:0] wr_addr,
   input  wire keqm_pkg::event_type        wr_data,
   input  wire logic                       rd_en,
   input  wire logic [keqm_pkg::IndexWidth-1:0] rd_addr,
   output      keqm_pkg::event_type        rd_data
);
   import keqm_pkg::*;

   event_type mem [QUEUE_DEPTH];
   event_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : keqm_event_ram
`default_nettype wire

// ===== hdl/keqm_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keqm_matrix
// Active-low 8x8 key matrix and its transposed copy, updated per popped event.
// ----------------------------------------------------------------------------
module keqm_matrix (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire keqm_pkg::apply_type                 upd,
   output      logic [keqm_pkg::MatrixWidth-1:0]    row_view,
   output      logic [keqm_pkg::MatrixWidth-1:0]    column_view
);
   import keqm_pkg::*;

   logic [MatrixWidth-1:0]   row_ff, row_in;
   logic [MatrixWidth-1:0]   col_ff, col_in;
   logic [MatrixWidth-1:0]   row_mask, col_mask;
   logic [BitIndexWidth-1:0] row_bit, col_bit;
   logic                     shifted;

   always_comb begin
      row_bit  = upd.key_event.code[5:0];
      col_bit  = {upd.key_event.code[2:0], upd.key_event.code[5:3]};
      shifted  = upd.key_event.code[7];
      row_mask = MatrixWidth'(1) << row_bit;
      col_mask = MatrixWidth'(1) << col_bit;
      if (shifted) begin
         row_mask = row_mask | (MatrixWidth'(1) << ShiftRowBit);
         col_mask = col_mask | (MatrixWidth'(1) << ShiftColBit);
      end
      row_in = row_ff;
      col_in = col_ff;
      // press wins over release; neither flag leaves the matrix alone
      if (upd.apply) begin
         if (upd.key_event.pressed) begin
            row_in = row_ff & ~row_mask;
            col_in = col_ff & ~col_mask;
         end else if (upd.key_event.released) begin
            row_in = row_ff | row_mask;
            col_in = col_ff | col_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '1;
         col_ff <= '1;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign row_view    = row_ff;
   assign column_view = col_ff;

endmodule : keqm_matrix
`default_nettype wire

// ===== hdl/key_event_queue_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_event_queue_matrix
// Key event FIFO feeding an emulated active-low 8x8 keyboard matrix.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low.
//   req_operation selects push (store the event) or poll (pop one event and
//   apply it to the row and column matrices).
//   Exactly one result follows each transaction, shown for one cycle with
//   rsp_strobe high; the receiver cannot hold it off.
//   A push, and a poll of an empty queue, give their result in the cycle
//   after acceptance and leave busy low, so one can be taken every cycle.
//   A poll that pops an event reads the event store through its registered
//   read port, then updates the matrices in ST_APPLY: busy is high for one
//   cycle and the result is registered at the end of ST_APPLY, so no new
//   transaction is taken until such a poll has finished its update.
//   rsp_row_view and rsp_column_view show the matrices after the
//   transaction; rsp_queue_count the events still queued.
//   Reset empties the queue and sets both matrices to all ones; the event
//   store itself is not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
module key_event_queue_matrix (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output      logic                                  busy,
   input  wire logic                                  req_operation,
   input  wire logic [7:0]                            req_key_code,
   input  wire logic                                  req_pressed,
   input  wire logic                                  req_released,
   output      logic                                  rsp_strobe,
   output      logic [keqm_pkg::MatrixWidth-1:0]      rsp_row_view,
   output      logic [keqm_pkg::MatrixWidth-1:0]      rsp_column_view,
   output      logic [keqm_pkg::QueueCountWidth-1:0]  rsp_queue_count,
   output      logic                                  rsp_push_dropped,
   output      logic                                  rsp_event_applied
);
   import keqm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [IndexWidth-1:0]  wr_idx_ff, wr_idx_in;
   logic [IndexWidth-1:0]  rd_idx_ff, rd_idx_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   strobe_ff, strobe_in;
   logic                   dropped_ff, dropped_in;
   logic                   applied_ff, applied_in;

   logic      accept, is_poll, full, empty;
   logic      do_push, do_pop;
   event_type push_event, ram_event;
   apply_type upd;

   assign accept  = start && (state_ff == ST_IDLE);
   assign is_poll = (req_operation == OP_POLL);
   assign full    = (count_ff == CountWidth'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = accept && !is_poll && !full;
   assign do_pop  = accept && is_poll && !empty;

   assign push_event = '{released: req_released, pressed: req_pressed,
                         code: req_key_code};

   keqm_event_ram u_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_idx_ff),
      .wr_data (push_event),
      .rd_en   (do_pop),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_event)
   );

   assign upd = '{apply: (state_ff == ST_APPLY), key_event: ram_event};

   keqm_matrix u_matrix (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .row_view    (rsp_row_view),
      .column_view (rsp_column_view)
   );

   always_comb begin
      state_in   = state_ff;
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      count_in   = count_ff;
      strobe_in  = 1'b0;
      dropped_in = dropped_ff;
      applied_in = applied_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (do_pop) begin
                  // result waits for the store read
                  state_in  = ST_APPLY;
                  rd_idx_in = (rd_idx_ff == IndexWidth'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_idx_ff + 1'b1;
                  count_in  = count_ff - 1'b1;
               end else begin
                  strobe_in  = 1'b1;
                  dropped_in = !is_poll && full;
                  applied_in = 1'b0;
                  if (do_push) begin
                     wr_idx_in = (wr_idx_ff == IndexWidth'(QUEUE_DEPTH - 1)) ?
                                 '0 : wr_idx_ff + 1'b1;
                     count_in  = count_ff + 1'b1;
                  end
               end
            end
         end
         ST_APPLY: begin
            state_in   = ST_IDLE;
            strobe_in  = 1'b1;
            dropped_in = 1'b0;
            applied_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dropped_ff <= dropped_in;
      applied_ff <= applied_in;
   end

   assign busy              = (state_ff == ST_APPLY);
   assign rsp_strobe        = strobe_ff;
   assign rsp_queue_count   = QueueCountWidth'(count_ff);
   assign rsp_push_dropped  = dropped_ff;
   assign rsp_event_applied = applied_ff;

`ifndef ASSERT_OFF
   a_apply_then_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |=> (rsp_strobe && rsp_event_applied))
      else $error("popped event gave no result after the matrix update");

   a_one_result_path : assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || state_ff == ST_APPLY))
      else $error("accepted transaction neither answered nor in apply");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QUEUE_DEPTH))
      else $error("event count beyond queue depth");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_push_dropped && rsp_event_applied))
      else $error("dropped and applied flagged together");
`endif

endmodule : key_event_queue_matrix
`default_nettype wire

// ===== tb/key_event_queue_matrix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_queue_matrix_checker
// Watches both channels of the key event queue, keeps its own copy of the
// event FIFO and of the row and column matrices, and compares every result
// field with the prediction made when the transaction was taken.
// ----------------------------------------------------------------------------
module key_event_queue_matrix_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic                                  req_operation,
   input  logic [7:0]                            req_key_code,
   input  logic                                  req_pressed,
   input  logic                                  req_released,
   input  logic                                  rsp_strobe,
   input  logic [keqm_pkg::MatrixWidth-1:0]      rsp_row_view,
   input  logic [keqm_pkg::MatrixWidth-1:0]      rsp_column_view,
   input  logic [keqm_pkg::QueueCountWidth-1:0]  rsp_queue_count,
   input  logic                                  rsp_push_dropped,
   input  logic                                  rsp_event_applied,
   output int                                    failures,
   output int                                    pending
);
   import keqm_pkg::*;

   typedef struct {
      logic [MatrixWidth-1:0]     row_view;
      logic [MatrixWidth-1:0]     column_view;
      logic [QueueCountWidth-1:0] queue_count;
      logic                       push_dropped;
      logic                       event_applied;
   } matrix_view_type;

   event_type               event_fifo [QUEUE_DEPTH];
   logic [IndexWidth-1:0]   fifo_wr_ptr;
   logic [IndexWidth-1:0]   fifo_rd_ptr;
   int                      fifo_level;
   logic [MatrixWidth-1:0]  key_rows;
   logic [MatrixWidth-1:0]  key_columns;
   matrix_view_type         expected_views [$];

   initial failures = 0;
   initial pending  = 0;

   task automatic report_error(input string what);
      $display("[%0t] key_event_queue_matrix: %s", $realtime, what);
      failures++;
   endtask

   // active low: a press clears the key bit, a release sets it again
   task automatic predict_key_transaction(input op_type op, input event_type ev);
      matrix_view_type view;
      event_type       popped;
      logic [2:0]      row;
      logic [2:0]      col;
      view.push_dropped  = 1'b0;
      view.event_applied = 1'b0;
      if (op == OP_PUSH) begin
         if (fifo_level < QUEUE_DEPTH) begin
            event_fifo[fifo_wr_ptr] = ev;
            fifo_wr_ptr++;
            fifo_level++;
         end else begin
            view.push_dropped = 1'b1;
         end
      end else if (fifo_level > 0) begin
         popped = event_fifo[fifo_rd_ptr];
         fifo_rd_ptr++;
         fifo_level--;
         view.event_applied = 1'b1;
         row = popped.code[5:3];
         col = popped.code[2:0];
         if (popped.pressed) begin
            if (popped.code[7]) begin
               key_rows[ShiftRowBit]    = 1'b0;
               key_columns[ShiftColBit] = 1'b0;
            end
            key_rows[{row, col}]    = 1'b0;
            key_columns[{col, row}] = 1'b0;
         end else if (popped.released) begin
            if (popped.code[7]) begin
               key_rows[ShiftRowBit]    = 1'b1;
               key_columns[ShiftColBit] = 1'b1;
            end
            key_rows[{row, col}]    = 1'b1;
            key_columns[{col, row}] = 1'b1;
         end
      end
      view.row_view    = key_rows;
      view.column_view = key_columns;
      view.queue_count = QueueCountWidth'(fifo_level);
      expected_views.push_back(view);
   endtask

   task automatic compare_result();
      matrix_view_type want;
      if (expected_views.size() == 0) begin
         report_error("result strobe with no transaction outstanding");
      end else begin
         want = expected_views.pop_front();
         if (rsp_row_view !== want.row_view)
            report_error($sformatf("row_view got %h expected %h",
                                   rsp_row_view, want.row_view));
         if (rsp_column_view !== want.column_view)
            report_error($sformatf("column_view got %h expected %h",
                                   rsp_column_view, want.column_view));
         if (rsp_queue_count !== want.queue_count)
            report_error($sformatf("queue_count got %0d expected %0d",
                                   rsp_queue_count, want.queue_count));
         if (rsp_push_dropped !== want.push_dropped)
            report_error($sformatf("push_dropped got %b expected %b",
                                   rsp_push_dropped, want.push_dropped));
         if (rsp_event_applied !== want.event_applied)
            report_error($sformatf("event_applied got %b expected %b",
                                   rsp_event_applied, want.event_applied));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fifo_wr_ptr = '0;
         fifo_rd_ptr = '0;
         fifo_level  = 0;
         key_rows    = '1;
         key_columns = '1;
         expected_views.delete();
      end else begin
         if (rsp_strobe === 1'b1)
            compare_result();
         if (start && !busy)
            predict_key_transaction(op_type'(req_operation),
                                    '{released: req_released, pressed: req_pressed,
                                      code: req_key_code});
      end
      pending <= expected_views.size();
   end

endmodule

// ===== tb/key_event_queue_matrix_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_queue_matrix_tb
// Drives push and poll transactions into the key event queue: a directed
// set of corner events, then a fill to overflow, a drain and a random mix,
// with random idle gaps on the request side. The checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module key_event_queue_matrix_tb;
   import keqm_pkg::*;

   localparam int CycleLimit = 100000;
   localparam int TailCycles = 8;

   logic                        clock         = 1'b0;
   logic                        reset         = 1'b1;
   logic                        start         = 1'b0;
   logic                        req_operation = 1'b0;
   logic [7:0]                  req_key_code  = 8'h00;
   logic                        req_pressed   = 1'b0;
   logic                        req_released  = 1'b0;
   logic                        busy;
   logic                        rsp_strobe;
   logic [MatrixWidth-1:0]      rsp_row_view;
   logic [MatrixWidth-1:0]      rsp_column_view;
   logic [QueueCountWidth-1:0]  rsp_queue_count;
   logic                        rsp_push_dropped;
   logic                        rsp_event_applied;
   int                          failures;
   int                          pending;

   // sender side bookkeeping, used to steer the stimulus and to time out the run
   int                          queue_level = 0;
   bit                          idle_on     = 1'b1;
   int                          cycle_count = 0;

   key_event_queue_matrix dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_key_code      (req_key_code),
      .req_pressed       (req_pressed),
      .req_released      (req_released),
      .rsp_strobe        (rsp_strobe),
      .rsp_row_view      (rsp_row_view),
      .rsp_column_view   (rsp_column_view),
      .rsp_queue_count   (rsp_queue_count),
      .rsp_push_dropped  (rsp_push_dropped),
      .rsp_event_applied (rsp_event_applied)
   );

   key_event_queue_matrix_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_key_code      (req_key_code),
      .req_pressed       (req_pressed),
      .req_released      (req_released),
      .rsp_strobe        (rsp_strobe),
      .rsp_row_view      (rsp_row_view),
      .rsp_column_view   (rsp_column_view),
      .rsp_queue_count   (rsp_queue_count),
      .rsp_push_dropped  (rsp_push_dropped),
      .rsp_event_applied (rsp_event_applied),
      .failures          (failures),
      .pending           (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   function automatic event_type key_event(input logic [7:0] code, input logic pressed,
                                           input logic released);
      event_type ev;
      ev.code     = code;
      ev.pressed  = pressed;
      ev.released = released;
      return ev;
   endfunction

   function automatic event_type random_key_event();
      return key_event(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
   endfunction

   // start stays high across back-to-back transactions; within this task it only drops for a gap
   task automatic send_event(input op_type op, input event_type ev);
      if (idle_on && $urandom_range(0, 99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_key_code  <= ev.code;
      req_pressed   <= ev.pressed;
      req_released  <= ev.released;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == OP_PUSH && queue_level < QUEUE_DEPTH)
         queue_level++;
      else if (op == OP_POLL && queue_level > 0)
         queue_level--;
   endtask

   task automatic send_random(input int push_percent);
      if ($urandom_range(0, 99) < push_percent)
         send_event(OP_PUSH, random_key_event());
      else
         send_event(OP_POLL, random_key_event());
   endtask

   task automatic wait_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner events: empty poll, both flags, neither flag, ignored bit 6,
      // shift together with the shift key position itself
      send_event(OP_POLL, key_event(8'h00, 1'b0, 1'b0));
      send_event(OP_PUSH, key_event(8'h00, 1'b1, 1'b0));
      send_event(OP_PUSH, key_event(8'hff, 1'b1, 1'b1));
      send_event(OP_PUSH, key_event(8'h80, 1'b0, 1'b1));
      send_event(OP_PUSH, key_event(8'h3f, 1'b0, 1'b0));
      send_event(OP_PUSH, key_event(8'h40, 1'b1, 1'b0));
      send_event(OP_PUSH, key_event(8'hb4, 1'b1, 1'b0));
      send_event(OP_PUSH, key_event(8'h34, 1'b0, 1'b1));
      send_event(OP_PUSH, key_event(8'h87, 1'b1, 1'b0));
      send_event(OP_PUSH, key_event(8'hc0, 1'b0, 1'b1));
      repeat (9) send_event(OP_POLL, key_event(8'hff, 1'b1, 1'b1));
      send_event(OP_POLL, key_event(8'h00, 1'b0, 1'b0));
      wait_until_drained();

      // fill to overflow, the first stretch with no gaps at all
      idle_on = 1'b0;
      for (int n = 0; queue_level < QUEUE_DEPTH; n++) begin
         if (n == 250)
            idle_on = 1'b1;
         send_random(95);
      end
      repeat (40) send_random(50);
      wait_until_drained();

      while (queue_level > 0)
         send_random(10);
      repeat (80) send_random(50);

      wait_until_drained();
      repeat (TailCycles) @(posedge clock);
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
